[rtl/core/rfam_pkg.sv]
// rfam_pkg: shared types and constants for the radial feather alpha mask
// word structs for the pixel and result channels, cell words, register map
// no dependencies
package rfam_pkg;

  // canvas side limits
  localparam logic [8:0] MIN_CANVAS = 9'd2;
  localparam logic [8:0] MAX_CANVAS = 9'd256;

  // register reset values
  localparam logic [8:0]  CANVAS_RESET = 9'd64;
  localparam logic [11:0] INNER_RESET  = 12'd384;
  localparam logic [11:0] OUTER_RESET  = 12'd512;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_CANVAS_SIZE = 2'd0;
  localparam logic [1:0] REG_INNER       = 2'd1;
  localparam logic [1:0] REG_OUTER       = 2'd2;

  // square root chain: 26-bit radicand, one root bit per cell
  localparam int SQRT_STEPS = 13;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = SQRT_STEPS + 1;

  // ramp division chain: one quotient bit per cell
  localparam int DIV_STEPS = 8;
  localparam int LOW_W     = DIV_STEPS;
  localparam int QUOT_W    = DIV_STEPS;
  localparam int PART_W    = 13;

  // input word
  typedef struct packed {
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] src_alpha;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_word_t;

  // sideband that travels with a pixel down the pipe
  typedef struct packed {
    logic       valid;
    logic       in_core;
    logic       outside;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } side_t;

  // word handed between square root cells
  typedef struct packed {
    side_t             side;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_word_t;

  // word handed between division cells
  typedef struct packed {
    side_t             side;
    logic [LOW_W-1:0]  low;
    logic [PART_W-1:0] part;
    logic [QUOT_W-1:0] quot;
  } div_word_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [8:0]  canvas_size;
    logic [11:0] inner_radius_q4;
    logic [11:0] outer_radius_q4;
    logic [23:0] inner_sq;
    logic [23:0] outer_sq;
  } cfg_t;

endpackage

[rtl/core/rfam_sqrt_cell.sv]
// rfam_sqrt_cell: one cell of the square root chain, one root bit per cycle
// takes the next radicand bit pair, passes the shifted word to its neighbor
// depends on rfam_pkg
module rfam_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  rfam_pkg::sqrt_word_t d,
  output rfam_pkg::sqrt_word_t q
);

  logic [rfam_pkg::REM_W+1:0]  cur;
  logic [rfam_pkg::ROOT_W+1:0] trial;
  logic [rfam_pkg::REM_W+1:0]  diff;
  logic                        ge;
  rfam_pkg::sqrt_word_t        q_next;

  // trial subtract of (4*root + 1) from the shifted remainder
  always_comb begin
    cur    = {d.rem, d.rad[rfam_pkg::RAD_W-1 -: 2]};
    trial  = {d.root, 2'b01};
    diff   = cur - {1'b0, trial};
    ge     = (cur >= {1'b0, trial});
    q_next = d;
    q_next.rad  = {d.rad[rfam_pkg::RAD_W-3:0], 2'b00};
    q_next.rem  = ge ? diff[rfam_pkg::REM_W-1:0] : cur[rfam_pkg::REM_W-1:0];
    q_next.root = {d.root[rfam_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

[rtl/core/rfam_div_cell.sv]
// rfam_div_cell: one cell of the ramp division chain, one quotient bit per cycle
// restoring step against the divisor, passes the shifted word to its neighbor
// depends on rfam_pkg
module rfam_div_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rfam_pkg::PART_W-1:0]  dvs,
  input  rfam_pkg::div_word_t          d,
  output rfam_pkg::div_word_t          q
);

  logic [rfam_pkg::PART_W:0] cur;
  logic [rfam_pkg::PART_W:0] diff;
  logic                      ge;
  rfam_pkg::div_word_t       q_next;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    cur    = {d.part, d.low[rfam_pkg::LOW_W-1]};
    diff   = cur - {1'b0, dvs};
    ge     = (cur >= {1'b0, dvs});
    q_next = d;
    q_next.low  = {d.low[rfam_pkg::LOW_W-2:0], 1'b0};
    q_next.part = ge ? diff[rfam_pkg::PART_W-1:0] : cur[rfam_pkg::PART_W-1:0];
    q_next.quot = {d.quot[rfam_pkg::QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

[rtl/core/rfam_regs.sv]
// rfam_regs: apb configuration registers of the feather mask
// canvas size and radii, plus registered squares of the radii
// depends on rfam_pkg
module rfam_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rfam_pkg::cfg_t cfg
);

  logic [8:0]  canvas_size;
  logic [11:0] inner_radius_q4;
  logic [11:0] outer_radius_q4;
  logic [23:0] inner_sq;
  logic [23:0] outer_sq;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_size     <= rfam_pkg::CANVAS_RESET;
      inner_radius_q4 <= rfam_pkg::INNER_RESET;
      outer_radius_q4 <= rfam_pkg::OUTER_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        rfam_pkg::REG_CANVAS_SIZE: canvas_size     <= pwdata[8:0];
        rfam_pkg::REG_INNER:       inner_radius_q4 <= pwdata[11:0];
        rfam_pkg::REG_OUTER:       outer_radius_q4 <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // radius squares for the inside and outside tests
  always_ff @(posedge clk) begin
    inner_sq <= inner_radius_q4 * inner_radius_q4;
    outer_sq <= outer_radius_q4 * outer_radius_q4;
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      rfam_pkg::REG_CANVAS_SIZE: prdata = {23'd0, canvas_size};
      rfam_pkg::REG_INNER:       prdata = {20'd0, inner_radius_q4};
      rfam_pkg::REG_OUTER:       prdata = {20'd0, outer_radius_q4};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.canvas_size     = canvas_size;
  assign cfg.inner_radius_q4 = inner_radius_q4;
  assign cfg.outer_radius_q4 = outer_radius_q4;
  assign cfg.inner_sq        = inner_sq;
  assign cfg.outer_sq        = outer_sq;

endmodule

[rtl/core/radial_feather_alpha_mask.sv]
// radial_feather_alpha_mask: top level, one pixel word per clock, never busy but in reset
// pipeline: two front stages, root seed, 13 root cells, divide seed, 8 divide cells,
// weight stage, then the output register that drives done and the result word
// throughput: one word per cycle, every stage and cell takes a new word each cycle
// reset: synchronous, clears pipeline valids and loads register defaults
// depends on rfam_pkg, rfam_regs, rfam_sqrt_cell, rfam_div_cell
module radial_feather_alpha_mask (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rfam_pkg::in_word_t  pixel,
  output logic                done,
  output rfam_pkg::out_word_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  rfam_pkg::cfg_t cfg;

  // front stages
  logic [8:0]      size_c;
  logic [11:0]     size8;
  logic [11:0]     px16;
  logic [11:0]     py16;
  rfam_pkg::side_t a_side;
  rfam_pkg::side_t a_side_next;
  logic [11:0]     a_dx;
  logic [11:0]     a_dy;
  rfam_pkg::side_t b_side;
  logic [23:0]     b_dx2;
  logic [23:0]     b_dy2;
  logic [24:0]     r2;
  rfam_pkg::sqrt_word_t c_word_next;

  // cell chains
  rfam_pkg::sqrt_word_t sq_chain [rfam_pkg::SQRT_STEPS+1];
  rfam_pkg::div_word_t  dv_chain [rfam_pkg::DIV_STEPS+1];

  // ramp numerator and divisor
  rfam_pkg::sqrt_word_t sq_last;
  logic [11:0]          ramp_d;
  logic [12:0]          dvs;
  logic [11:0]          num;
  logic [20:0]          numer;
  rfam_pkg::div_word_t  d_word_next;

  // weight and output stages
  rfam_pkg::div_word_t  dv_last;
  logic [7:0]           weight;
  rfam_pkg::side_t      w_side;
  logic [15:0]          w_prod;
  logic                 w_zero;
  logic [16:0]          rnd;
  logic [16:0]          quo;
  rfam_pkg::out_word_t  result_next;

  assign busy = rst;

  rfam_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clamp canvas size, offsets of the pixel centre in sixteenths
  always_comb begin
    if (cfg.canvas_size < rfam_pkg::MIN_CANVAS) begin
      size_c = rfam_pkg::MIN_CANVAS;
    end else if (cfg.canvas_size > rfam_pkg::MAX_CANVAS) begin
      size_c = rfam_pkg::MAX_CANVAS;
    end else begin
      size_c = cfg.canvas_size;
    end
    size8 = {size_c, 3'b000};
    px16  = {pixel.x_pos, 4'b1000};
    py16  = {pixel.y_pos, 4'b1000};
    a_side_next.valid   = start & ~busy;
    a_side_next.in_core = 1'b0;
    a_side_next.outside = 1'b0;
    a_side_next.alpha   = pixel.src_alpha;
    a_side_next.red     = pixel.src_red;
    a_side_next.green   = pixel.src_green;
    a_side_next.blue    = pixel.src_blue;
  end

  // stage a: offset magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_side <= '0;
    end else begin
      a_side <= a_side_next;
    end
    a_dx   <= (px16 >= size8) ? (px16 - size8) : (size8 - px16);
    a_dy   <= (py16 >= size8) ? (py16 - size8) : (size8 - py16);
  end

  // stage b: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      b_side <= '0;
    end else begin
      b_side <= a_side;
    end
    b_dx2  <= a_dx * a_dx;
    b_dy2  <= a_dy * a_dy;
  end

  // stage c: radius squared, inside and outside tests, seed of the root chain
  always_comb begin
    r2 = {1'b0, b_dx2} + {1'b0, b_dy2};
    c_word_next              = '0;
    c_word_next.side         = b_side;
    c_word_next.side.in_core = (r2 <= {1'b0, cfg.inner_sq});
    c_word_next.side.outside = (r2 > {1'b0, cfg.inner_sq}) && (r2 >= {1'b0, cfg.outer_sq});
    c_word_next.rad          = {1'b0, r2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_chain[0] <= '0;
    end else begin
      sq_chain[0] <= c_word_next;
    end
  end

  // root chain
  for (genvar i = 0; i < rfam_pkg::SQRT_STEPS; i++) begin : g_sqrt
    rfam_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (sq_chain[i]),
      .q   (sq_chain[i+1])
    );
  end

  // stage d: ramp numerator 510*(outer - r) + d over divisor 2*d
  always_comb begin
    sq_last = sq_chain[rfam_pkg::SQRT_STEPS];
    ramp_d  = cfg.outer_radius_q4 - cfg.inner_radius_q4;
    dvs     = {ramp_d, 1'b0};
    if (sq_last.root < {1'b0, cfg.outer_radius_q4}) begin
      num = cfg.outer_radius_q4 - sq_last.root[11:0];
    end else begin
      num = 12'd0;
    end
    numer = {num, 9'd0} - {8'd0, num, 1'b0} + {9'd0, ramp_d};
    d_word_next      = '0;
    d_word_next.side = sq_last.side;
    d_word_next.part = numer[20:8];
    d_word_next.low  = numer[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_chain[0] <= '0;
    end else begin
      dv_chain[0] <= d_word_next;
    end
  end

  // divide chain
  for (genvar j = 0; j < rfam_pkg::DIV_STEPS; j++) begin : g_div
    rfam_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .dvs (dvs),
      .d   (dv_chain[j]),
      .q   (dv_chain[j+1])
    );
  end

  // stage w: feather weight and alpha product
  always_comb begin
    dv_last = dv_chain[rfam_pkg::DIV_STEPS];
    if (dv_last.side.in_core) begin
      weight = 8'd255;
    end else if (dv_last.side.outside) begin
      weight = 8'd0;
    end else begin
      weight = dv_last.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_side <= '0;
    end else begin
      w_side <= dv_last.side;
    end
    w_prod <= dv_last.side.alpha * weight;
    w_zero <= (weight == 8'd0);
  end

  // stage o: rounded divide by 255, zero mask where the feather weight is zero
  always_comb begin
    rnd = {1'b0, w_prod} + 17'd127;
    quo = (rnd + 17'd1 + {8'd0, rnd[16:8]}) >> 8;
    if (w_zero) begin
      result_next = '0;
    end else begin
      result_next.out_alpha = quo[7:0];
      result_next.out_red   = w_side.red;
      result_next.out_green = w_side.green;
      result_next.out_blue  = w_side.blue;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= w_side.valid;
    end
  end

endmodule

[test/rfam_checker.sv]
// rfam_checker: watches the pixel, result and register ports of the feather mask
// predicts each result word from its own register copy and compares field by field
// depends on rfam_pkg
module rfam_checker
  import rfam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  in_word_t    pixel,
  input  logic        done,
  input  out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_PRINTS = 30;

  // register copy as the datapath should see it
  logic [8:0]  size_q;
  logic [11:0] inner_q;
  logic [11:0] outer_q;

  out_word_t masked_words[$];
  out_word_t want;

  // floor of the square root, one root bit per trial from the top
  function automatic longint root_floor(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // expected result word for one pixel word under the given registers
  function automatic out_word_t feather_pixel(input in_word_t w, input logic [8:0] size_reg,
                                              input logic [11:0] inner_reg,
                                              input logic [11:0] outer_reg);
    longint side, dx, dy, r2, inner, outer, root, span, num, weight;
    out_word_t o;
    side = size_reg;
    if (side < longint'(MIN_CANVAS)) side = MIN_CANVAS;
    if (side > longint'(MAX_CANVAS)) side = MAX_CANVAS;
    inner = inner_reg;
    outer = outer_reg;
    // pixel centre offsets in sixteenths of a pixel
    dx = 16 * longint'(w.x_pos) + 8 - 8 * side;
    dy = 16 * longint'(w.y_pos) + 8 - 8 * side;
    r2 = dx * dx + dy * dy;
    // opaque core, transparent rim, rounded ramp between
    if (r2 <= inner * inner) begin
      weight = 255;
    end else if (r2 >= outer * outer) begin
      weight = 0;
    end else begin
      root = root_floor(r2);
      span = outer - inner;
      num = (root < outer) ? outer - root : 0;
      weight = (510 * num + span) / (2 * span);
      if (weight > 255) weight = 255;
    end
    if (weight == 0) begin
      o = '0;
    end else begin
      o.out_alpha = 8'((longint'(w.src_alpha) * weight + 127) / 255);
      o.out_red   = w.src_red;
      o.out_green = w.src_green;
      o.out_blue  = w.src_blue;
    end
    return o;
  endfunction

  // one line per mismatch, quiet after a while but still counted
  task automatic report_mismatch(input string what, input longint got, input longint wanted);
    if (fail_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, wanted);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      masked_words.delete();
      size_q  <= CANVAS_RESET;
      inner_q <= INNER_RESET;
      outer_q <= OUTER_RESET;
    end else begin
      // accepted pixel word
      if (start && !busy)
        masked_words.push_back(feather_pixel(pixel, size_q, inner_q, outer_q));
      // result word against the oldest prediction
      if (done) begin
        if (masked_words.size() == 0) begin
          report_mismatch("result word with none pending", result, 0);
        end else begin
          want = masked_words.pop_front();
          if (result.out_alpha != want.out_alpha)
            report_mismatch("out_alpha", result.out_alpha, want.out_alpha);
          if (result.out_red != want.out_red)
            report_mismatch("out_red", result.out_red, want.out_red);
          if (result.out_green != want.out_green)
            report_mismatch("out_green", result.out_green, want.out_green);
          if (result.out_blue != want.out_blue)
            report_mismatch("out_blue", result.out_blue, want.out_blue);
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CANVAS_SIZE: size_q  <= pwdata[8:0];
          REG_INNER:       inner_q <= pwdata[11:0];
          REG_OUTER:       outer_q <= pwdata[11:0];
          default: ;
        endcase
      end
      // register read back
      if (psel && penable && !pwrite && pready) begin
        case (paddr[3:2])
          REG_CANVAS_SIZE:
            if (prdata !== 32'(size_q)) report_mismatch("canvas_size read", prdata, size_q);
          REG_INNER:
            if (prdata !== 32'(inner_q)) report_mismatch("inner_radius_q4 read", prdata, inner_q);
          REG_OUTER:
            if (prdata !== 32'(outer_q)) report_mismatch("outer_radius_q4 read", prdata, outer_q);
          default: ;
        endcase
      end
    end
    pending <= masked_words.size();
  end

endmodule

[test/radial_feather_alpha_mask_tb.sv]
// radial_feather_alpha_mask_tb: stimulus and verdict for the radial feather alpha mask
// drives pixel words in bursts and programs registers between phases
// depends on rfam_pkg, rfam_checker and the radial_feather_alpha_mask rtl
module radial_feather_alpha_mask_tb;
  import rfam_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 92;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    pixel = '0;
  logic        done;
  out_word_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_words;
  int quiet_cycles = 0;
  int burst_left = 0;
  int cur_side = 64;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radial_feather_alpha_mask u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rfam_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel      (pixel),
    .done       (done),
    .result     (result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending_words)
  );

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("radial_feather_alpha_mask regression: fail");
      $finish;
    end
  end

  // one pixel word, then maybe a gap that ends the burst
  task automatic send_pixel(input in_word_t w);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    pixel <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_xy(input logic [7:0] x, input logic [7:0] y, input logic [7:0] a,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_word_t w;
    w.x_pos = x;
    w.y_pos = y;
    w.src_alpha = a;
    w.src_red = r;
    w.src_green = g;
    w.src_blue = b;
    send_pixel(w);
  endtask

  // stop sending and wait for every result word
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0) @(posedge clk);
  endtask

  // register access: setup cycle, then access cycle
  task automatic apb_access(input logic is_write, input logic [1:0] idx,
                            input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_back();
    apb_access(1'b0, REG_CANVAS_SIZE, '0);
    apb_access(1'b0, REG_INNER, '0);
    apb_access(1'b0, REG_OUTER, '0);
  endtask

  task automatic program_regs(input int unsigned side, input int unsigned inner,
                              input int unsigned outer);
    apb_access(1'b1, REG_CANVAS_SIZE, 32'(side));
    apb_access(1'b1, REG_INNER, 32'(inner));
    apb_access(1'b1, REG_OUTER, 32'(outer));
    read_back();
    if (side < 2) cur_side = 2;
    else if (side > 256) cur_side = 256;
    else cur_side = side;
  endtask

  // random setting: mostly radii scaled to the canvas, sometimes wild
  task automatic random_setup();
    int unsigned side, half, inner, outer;
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 5))
        0: side = 0;
        1: side = 1;
        2: side = 2;
        3: side = 256;
        4: side = 257;
        default: side = 511;
      endcase
    end else begin
      side = $urandom_range(2, 256);
    end
    half = (side < 2) ? 16 : ((side > 256) ? 2048 : side * 8);
    case ($urandom_range(0, 7))
      0: begin
        inner = $urandom_range(0, 4095);
        outer = $urandom_range(0, 4095);
      end
      1: begin
        inner = $urandom_range(0, half);
        outer = $urandom_range(0, inner);
      end
      default: begin
        inner = $urandom_range(0, half);
        outer = inner + $urandom_range(1, half);
      end
    endcase
    if (outer > 4095) outer = 4095;
    program_regs(side, inner, outer);
  endtask

  task automatic random_pixel();
    logic [7:0] x, y, a;
    x = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, cur_side - 1));
    y = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, cur_side - 1));
    case ($urandom_range(0, 9))
      0: a = 8'd0;
      1: a = 8'd255;
      2: a = 8'd1;
      default: a = 8'($urandom_range(0, 255));
    endcase
    send_xy(x, y, a, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, then the default 64 canvas with 24..32 pixel feather
    read_back();
    send_xy(8'd32, 8'd32, 8'd255, 8'd255, 8'd255, 8'd255);
    send_xy(8'd31, 8'd31, 8'd0, 8'd0, 8'd0, 8'd0);
    send_xy(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    send_xy(8'd255, 8'd255, 8'd200, 8'h55, 8'hAA, 8'h55);
    send_xy(8'd55, 8'd31, 8'd128, 8'hAA, 8'h55, 8'hAA);
    send_xy(8'd56, 8'd32, 8'd255, 8'h12, 8'h34, 8'h56);
    send_xy(8'd60, 8'd31, 8'd77, 8'h80, 8'h01, 8'hFE);
    send_xy(8'd62, 8'd31, 8'd255, 8'h7F, 8'hF7, 8'h01);
    // weight nonzero but alpha rounds to zero: colour still passes
    send_xy(8'd63, 8'd31, 8'd1, 8'hC3, 8'h3C, 8'h99);
    send_xy(8'd64, 8'd31, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_xy(8'd31, 8'd8, 8'd255, 8'h0F, 8'hF0, 8'h0F);
    send_xy(8'd128, 8'd31, 8'd255, 8'd1, 8'd2, 8'd3);
    drain();

    // canvas below range saturates to two, narrow ramp from zero
    program_regs(0, 0, 16);
    send_xy(8'd0, 8'd0, 8'd255, 8'd10, 8'd20, 8'd30);
    send_xy(8'd1, 8'd1, 8'd100, 8'd40, 8'd50, 8'd60);
    send_xy(8'd255, 8'd0, 8'd255, 8'd70, 8'd80, 8'd90);
    drain();

    // canvas above range saturates, radii at the top of the field
    program_regs(511, 4095, 4095);
    send_xy(8'd0, 8'd0, 8'd255, 8'hA5, 8'h5A, 8'hA5);
    send_xy(8'd255, 8'd0, 8'd3, 8'h5A, 8'hA5, 8'h5A);
    drain();

    // outer not above inner: inside wins, else transparent
    program_regs(64, 100, 50);
    send_xy(8'd32, 8'd32, 8'd250, 8'd11, 8'd22, 8'd33);
    send_xy(8'd40, 8'd32, 8'd250, 8'd44, 8'd55, 8'd66);
    drain();

    // both radii zero on the smallest canvas
    program_regs(2, 0, 0);
    send_xy(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255);
    send_xy(8'd1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    drain();

    // random phases
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_setup();
      for (int i = 0; i < PHASE_WORDS; i++) random_pixel();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("radial_feather_alpha_mask regression: pass");
    end else begin
      $display("radial_feather_alpha_mask regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rfam_pkg.sv
rtl/core/rfam_sqrt_cell.sv
rtl/core/rfam_div_cell.sv
rtl/core/rfam_regs.sv
rtl/core/radial_feather_alpha_mask.sv
test/rfam_checker.sv
test/radial_feather_alpha_mask_tb.sv
